// ===== rtl/b64enc_pkg.sv =====
// ----------------------------------------------------------------------------
// b64enc_pkg
// Shared types, constants and the alphabet map for the Base64 stream encoder.
// ----------------------------------------------------------------------------
package b64enc_pkg;

  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [6:0] CharUpperA = 7'h41;
  localparam logic [6:0] CharLowerA = 7'h61;
  localparam logic [6:0] CharZero   = 7'h30;
  localparam logic [6:0] CharPlus   = 7'h2B;
  localparam logic [6:0] CharSlash  = 7'h2F;
  localparam logic [6:0] CharPad    = 7'h3D;

  localparam logic [5:0] NumUpper = 6'd26;
  localparam logic [5:0] NumAlpha = 6'd52;
  localparam logic [5:0] NumAlnum = 6'd62;

  typedef logic [5:0] grp_t;

  typedef struct packed {
    grp_t [3:0] grp;
    logic [3:0] pad;
    logic [1:0] n_m1;
    logic       last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [6:0] sym_of(input grp_t g);
    logic [6:0] gx;
    logic [6:0] res;
    gx = {1'b0, g};
    if (g < NumUpper) begin
      res = CharUpperA + gx;
    end else if (g < NumAlpha) begin
      res = CharLowerA + gx - {1'b0, NumUpper};
    end else if (g < NumAlnum) begin
      res = CharZero + gx - {1'b0, NumAlpha};
    end else if (g == NumAlnum) begin
      res = CharPlus;
    end else begin
      res = CharSlash;
    end
    return res;
  endfunction

endpackage

// ===== rtl/base64_stream_encoder_top.sv =====
// ----------------------------------------------------------------------------
// base64_stream_encoder_top
// Streaming Base64 encoder: bytes in, standard-alphabet characters out.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                | tlast        | tuser
//  s_axis  | in  | [7:0] data_byte      | is_last      | -
//  m_axis  | out | [6:0] symbol, [7] 0  | message_last | [0] run_last
//
// One character leaves per cycle from the output register unless m_axis_tready
// holds it; the front end builds each byte's job combinationally, and the back
// end emits 1 to 4 characters a byte (1 or 2 mid message, 2 to 4 with padding last).
// A two-entry job queue lets bytes enter while earlier characters drain.
// Synchronous active-high reset clears leftover bits, queue and output valid.
// ----------------------------------------------------------------------------
module base64_stream_encoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [6:0] symbol, [7] zero
  output logic       m_axis_tlast,
  output logic       m_axis_tuser    // [0] run_last
);

  b64enc_pkg::job_t   wjob;
  b64enc_pkg::job_t   rjob;
  b64enc_pkg::qstat_t qstat;
  logic               q_push;
  logic               q_pop;
  logic [6:0]         symbol;

  b64enc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .data_byte (s_axis_tdata),
    .is_last   (s_axis_tlast),
    .qstat     (qstat),
    .push      (q_push),
    .job       (wjob)
  );

  b64enc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wjob  (wjob),
    .pop   (q_pop),
    .rjob  (rjob),
    .qstat (qstat)
  );

  b64enc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (rjob),
    .qstat        (qstat),
    .pop          (q_pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .symbol       (symbol),
    .run_last     (m_axis_tuser),
    .message_last (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, symbol};

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !qstat.full)
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !qstat.empty)
    else $error("job queue underflow");

  a_status_sane: assert property (@(posedge clk) disable iff (rst)
    !(qstat.full && qstat.empty))
    else $error("job queue full and empty at once");

  a_msg_ends_run: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
    else $error("message end outside run end");
`endif

endmodule

// ===== rtl/b64enc_front.sv =====
// ----------------------------------------------------------------------------
// b64enc_front
// Accepts message bytes, tracks leftover bits and builds one character job.
// ----------------------------------------------------------------------------
module b64enc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               is_last,
  input  b64enc_pkg::qstat_t qstat,
  output logic               push,
  output b64enc_pkg::job_t   job
);

  logic [3:0] pending_bits;
  logic [3:0] pending_bits_next;
  logic [1:0] pending_count;
  logic [1:0] pending_count_next;

  assign in_ready = !qstat.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    job                = '0;
    job.last           = is_last;
    pending_bits_next  = '0;
    pending_count_next = '0;
    case (pending_count)
      2'd1: begin
        job.grp[0] = {pending_bits[1:0], data_byte[7:4]};
        if (is_last) begin
          job.grp[1] = {data_byte[3:0], 2'b00};
          job.pad[2] = 1'b1;
          job.n_m1   = 2'd2;
        end else begin
          job.n_m1           = 2'd0;
          pending_bits_next  = data_byte[3:0];
          pending_count_next = 2'd2;
        end
      end
      2'd2: begin
        job.grp[0] = {pending_bits, data_byte[7:6]};
        job.grp[1] = data_byte[5:0];
        job.n_m1   = 2'd1;
      end
      default: begin
        job.grp[0] = data_byte[7:2];
        if (is_last) begin
          job.grp[1] = {data_byte[1:0], 4'b0000};
          job.pad[2] = 1'b1;
          job.pad[3] = 1'b1;
          job.n_m1   = 2'd3;
        end else begin
          job.n_m1           = 2'd0;
          pending_bits_next  = {2'b00, data_byte[1:0]};
          pending_count_next = 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
    end else if (push) begin
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
    end
  end

endmodule

// ===== rtl/b64enc_queue.sv =====
// ----------------------------------------------------------------------------
// b64enc_queue
// Short job queue between the byte front end and the character back end.
// ----------------------------------------------------------------------------
module b64enc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  b64enc_pkg::job_t   wjob,
  input  logic               pop,
  output b64enc_pkg::job_t   rjob,
  output b64enc_pkg::qstat_t qstat
);

  b64enc_pkg::job_t                   mem [b64enc_pkg::QDepth];
  logic [b64enc_pkg::QPtrW-1:0]       wptr;
  logic [b64enc_pkg::QPtrW-1:0]       rptr;
  logic [b64enc_pkg::QCntW-1:0]       count;

  assign rjob        = mem[rptr];
  assign qstat.full  = (count == b64enc_pkg::QCntW'(b64enc_pkg::QDepth));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wjob;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/b64enc_back.sv =====
// ----------------------------------------------------------------------------
// b64enc_back
// Walks the head job one character per cycle, unless the output stalls, into the output register.
// ----------------------------------------------------------------------------
module b64enc_back (
  input  logic               clk,
  input  logic               rst,
  input  b64enc_pkg::job_t   head,
  input  b64enc_pkg::qstat_t qstat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [6:0]         symbol,
  output logic               run_last,
  output logic               message_last
);

  logic [1:0] idx;
  logic       advance;
  logic       fire;
  logic       at_end;
  logic [6:0] sym_next;

  assign advance = !out_valid || out_ready;
  assign fire    = advance && !qstat.empty;
  assign at_end  = (idx == head.n_m1);
  assign pop     = fire && at_end;

  always_comb begin
    if (head.pad[idx]) begin
      sym_next = b64enc_pkg::CharPad;
    end else begin
      sym_next = b64enc_pkg::sym_of(head.grp[idx]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (advance) begin
      out_valid <= !qstat.empty;
      if (fire) begin
        idx <= at_end ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      symbol       <= sym_next;
      run_last     <= at_end;
      message_last <= at_end && head.last;
    end
  end

endmodule
